[hdl/led_fill_animation_pwm_unit_assert.svh]
// Assertion macros for the LED fill animation PWM unit.
`ifndef LED_FILL_ANIMATION_PWM_UNIT_ASSERT_SVH
`define LED_FILL_ANIMATION_PWM_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define LFAP_ASSERT_SAME(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("lfap: %s failed", "lbl");

// Condition implies consequence in the next cycle.
`define LFAP_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("lfap: %s failed", "lbl");

`endif

[hdl/lfap_pkg.sv]
// Package: constants and types for the LED fill animation PWM unit.
package lfap_pkg;

  localparam int NUM_LETTERS_DEF = 5;
  localparam int RAMP_STEPS_DEF  = 256;

  localparam int STEP_W  = 12;
  localparam int LEVEL_W = 8;
  localparam int PROD_W  = 2 * LEVEL_W;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
  localparam logic [LEVEL_W-1:0] PWM_LAST   = 8'd254;

  localparam logic [LEVEL_W-1:0] GAIN_RST      = 8'd51;
  localparam logic [LEVEL_W-1:0] TICKS_RST     = 8'd200;
  localparam logic [LEVEL_W-1:0] BACKLIGHT_RST = 8'd255;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GAIN      = 2'd0;
  localparam cfg_idx_t CFG_TICKS     = 2'd1;
  localparam cfg_idx_t CFG_BACKLIGHT = 2'd2;

endpackage

[hdl/led_fill_animation_pwm_unit.sv]
// Top level: LED fill animation with software PWM, two-stage pipeline.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per timer tick:
//   in_tick_advance = 1 advances the counters after sampling them, 0 only
//   reports. Each input word yields exactly one result word on the output
//   channel (out_valid/out_ready): out_led_pattern (letters in bits
//   0..NUM_LETTERS-1, backlight above) and out_anim_step.
//   The pattern is taken from the counters as they stood before the tick.
//   A word passes stage 1, then stage 2, before out_valid. Throughput
//   is one word per cycle while out_ready is high: stage 1 holds the
//   level multiplies, stage 2 the PWM compares and the result register.
//   Configuration: cfg_wr_en with cfg_index 0 gain, 1 ticks per step,
//   2 backlight level; other indexes are ignored. Write only when idle.
//   Reset (rst_n low, synchronous) clears the counters, empties the
//   pipeline and loads gain 51, 200 ticks per step, backlight 255.
//   When out_ready is low the result holds, stage 1 fills, and in_ready
//   drops only once both stages hold a word.
`include "led_fill_animation_pwm_unit_assert.svh"

module led_fill_animation_pwm_unit #(
  parameter int NumLetters = lfap_pkg::NUM_LETTERS_DEF,
  parameter int RampSteps  = lfap_pkg::RAMP_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  lfap_pkg::cfg_idx_t            cfg_index,
  input  logic [lfap_pkg::LEVEL_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_tick_advance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [NumLetters:0]           out_led_pattern,
  output logic [lfap_pkg::STEP_W-1:0]   out_anim_step
);

  localparam int LW     = lfap_pkg::LEVEL_W;
  localparam int PW     = lfap_pkg::PROD_W;
  localparam int SW     = lfap_pkg::STEP_W;
  localparam int Phases = 2 * NumLetters;
  localparam int PhW    = (Phases > 1) ? $clog2(Phases) : 1;
  localparam int PosW   = $clog2(RampSteps);
  localparam int Total  = Phases * RampSteps;
  localparam int RampDen = RampSteps - 1;
  localparam int RampInc = 255 / RampDen;
  localparam int RampRem = 255 % RampDen;

  localparam logic [SW-1:0]   LastStep  = SW'(Total - 1);
  localparam logic [PhW-1:0]  LastPhase = PhW'(Phases - 1);
  localparam logic [PhW-1:0]  NumLetPh  = PhW'(NumLetters);
  localparam logic [PosW-1:0] LastPos   = PosW'(RampSteps - 1);
  localparam logic [LW:0]     RampDenW  = (LW+1)'(RampDen);

  // configuration
  logic [LW-1:0] gain_r, ticks_r, bl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= lfap_pkg::GAIN_RST;
      ticks_r <= lfap_pkg::TICKS_RST;
      bl_r    <= lfap_pkg::BACKLIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lfap_pkg::CFG_GAIN:      gain_r  <= cfg_data;
        lfap_pkg::CFG_TICKS:     ticks_r <= cfg_data;
        lfap_pkg::CFG_BACKLIGHT: bl_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_r, s1_valid_r;
  logic out_adv, s1_adv, in_acc;

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;
  assign in_acc   = in_valid && in_ready;

  // animation state
  logic [LW-1:0]   pwm_r, pwm_nxt;
  logic [LW-1:0]   ps_r, ps_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic [PhW-1:0]  phase_r, phase_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [LW-1:0]   ramp_r, ramp_nxt;
  logic [LW-1:0]   rem_r, rem_nxt;

  logic [LW-1:0] ps_inc;
  logic          step_end;
  logic [LW:0]   rem_sum;

  always_comb begin
    pwm_nxt   = pwm_r;
    ps_nxt    = ps_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    ramp_nxt  = ramp_r;
    rem_nxt   = rem_r;
    ps_inc    = ps_r + 8'd1;
    step_end  = (ps_inc >= ticks_r) || (ps_inc == '0);
    rem_sum   = {1'b0, rem_r} + (LW+1)'(RampRem);
    if (in_acc && in_tick_advance) begin
      pwm_nxt = (pwm_r >= lfap_pkg::PWM_LAST) ? '0 : pwm_r + 8'd1;
      ps_nxt  = step_end ? '0 : ps_inc;
      if (step_end) begin
        step_nxt = (step_r == LastStep) ? '0 : step_r + 1'b1;
        if (pos_r == LastPos) begin
          pos_nxt   = '0;
          ramp_nxt  = '0;
          rem_nxt   = '0;
          phase_nxt = (phase_r == LastPhase) ? '0 : phase_r + 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
          if (rem_sum >= RampDenW) begin
            ramp_nxt = ramp_r + LW'(RampInc) + 8'd1;
            rem_nxt  = LW'(rem_sum - RampDenW);
          end else begin
            ramp_nxt = ramp_r + LW'(RampInc);
            rem_nxt  = LW'(rem_sum);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_r   <= '0;
      ps_r    <= '0;
      step_r  <= '0;
      phase_r <= '0;
      pos_r   <= '0;
      ramp_r  <= '0;
      rem_r   <= '0;
    end else begin
      pwm_r   <= pwm_nxt;
      ps_r    <= ps_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ramp_r  <= ramp_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // stage 1: channel roles and level products
  logic                  fill_ph;
  logic [PhW-1:0]        ramp_ch;
  logic [LW-1:0]         ramp_lvl;
  logic [LW:0]           pwm_inc;
  logic [NumLetters-1:0] full_mask, rsel_mask;

  always_comb begin
    fill_ph  = (phase_r < NumLetPh);
    ramp_ch  = fill_ph ? phase_r : phase_r - NumLetPh;
    ramp_lvl = fill_ph ? ramp_r : lfap_pkg::FULL_LEVEL - ramp_r;
    pwm_inc  = {1'b0, pwm_r} + 9'd1;
    for (int c = 0; c < NumLetters; c++) begin
      rsel_mask[c] = (PhW'(c) == ramp_ch);
      full_mask[c] = fill_ph ? (PhW'(c) < ramp_ch) : (PhW'(c) > ramp_ch);
    end
  end

  logic [SW-1:0]         s1_step_r;
  logic [NumLetters-1:0] s1_full_r, s1_rsel_r;
  logic                  s1_full_lit_r;
  logic [PW-1:0]         s1_rprod_r, s1_bprod_r, s1_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_step_r     <= step_r;
      s1_full_r     <= full_mask;
      s1_rsel_r     <= rsel_mask;
      s1_full_lit_r <= (pwm_r < gain_r);
      s1_rprod_r    <= ramp_lvl * gain_r;
      s1_bprod_r    <= bl_r * gain_r;
      s1_thr_r      <= PW'({pwm_inc, 8'd0} - {8'd0, pwm_inc});
    end
  end

  // stage 2: PWM compare and result register
  logic [NumLetters:0] pattern;

  always_comb begin
    for (int c = 0; c < NumLetters; c++) begin
      pattern[c] = (s1_full_r[c] && s1_full_lit_r) ||
                   (s1_rsel_r[c] && (s1_rprod_r >= s1_thr_r));
    end
    pattern[NumLetters] = (s1_bprod_r >= s1_thr_r);
  end

  logic [NumLetters:0] out_pat_r;
  logic [SW-1:0]       out_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_pat_r  <= pattern;
      out_step_r <= s1_step_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_pattern = out_pat_r;
  assign out_anim_step   = out_step_r;

  // assertions
  `LFAP_ASSERT_SAME(a_step_range, 1'b1, step_r <= LastStep)
  `LFAP_ASSERT_NEXT(a_s1_hold, s1_valid_r && !out_adv, s1_valid_r && $stable(s1_step_r))
  `LFAP_ASSERT_NEXT(a_no_tick, in_acc && !in_tick_advance, $stable(step_r) && $stable(pwm_r))
  `LFAP_ASSERT_SAME(a_step_sync, 1'b1, (pos_r != '0) || (ramp_r == '0))

endmodule
